// ----- hdl/wgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// wgrs_pkg - shared constants for the widest gap row splitter
// Field widths, register map and reset values.
// ----------------------------------------------------------------------------
package wgrs_pkg;

    localparam int unsigned MAX_PIECES_DEF = 16;

    localparam int unsigned COORD_W  = 20;
    localparam int unsigned HEIGHT_W = 20;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned AFTER_W  = 4;
    localparam int unsigned PCOUNT_W = 5;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MEDIAN_HEIGHT = 2'd0;
    localparam logic [1:0] REG_GAP_FRACTION  = 2'd1;
    localparam logic [1:0] REG_GAP_RATIO     = 2'd2;

    localparam logic [HEIGHT_W-1:0] MEDIAN_HEIGHT_RST = 20'd320;
    localparam logic [FRAC_W-1:0]   GAP_FRACTION_RST  = 8'd24;   // 1.5 in Q4.4
    localparam logic [FRAC_W-1:0]   GAP_RATIO_RST     = 8'd48;   // 3.0 in Q4.4

endpackage

// ----- hdl/wgrs_gap_mem.sv -----
// ----------------------------------------------------------------------------
// wgrs_gap_mem - gap store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wgrs_gap_mem
    import wgrs_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_PIECES_DEF - 1,
    parameter int unsigned AW    = $clog2(MAX_PIECES_DEF - 1)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [COORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [COORD_W-1:0] o_rd_data
);

    logic [COORD_W-1:0] r_mem [DEPTH];
    logic [COORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/widest_gap_row_splitter_top.sv -----
// ----------------------------------------------------------------------------
// widest_gap_row_splitter_top - label/value split at the widest gap of a row
// Stores piece gaps, tracks the first widest, then selects the upper median
//  of the remaining gaps by rank counting through the gap store's read port.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  piece in  i_left_x, i_right_x, i_last_piece       start & !busy
//  result    o_split_found, o_split_after,           o_done, one cycle
//            o_piece_count, o_overflow
//  config    psel/penable/pwrite/paddr/pwdata        APB, pready tied high
//
//  A piece that is not last leaves busy low.
//  A last piece raises busy until the result; when the median is needed, the
//  sequencer does rank counting of each candidate against every stored gap
//  through the single read port of the gap store.
//  Synchronous active-low reset; the gap store needs no clearing pass.
//  The result is shown for one cycle and cannot be held off.
module widest_gap_row_splitter_top
    import wgrs_pkg::*;
#(
    parameter int unsigned MAX_PIECES = MAX_PIECES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [COORD_W-1:0]  i_left_x,
    input  logic [COORD_W-1:0]  i_right_x,
    input  logic                i_last_piece,
    output logic                o_done,
    output logic                o_split_found,
    output logic [AFTER_W-1:0]  o_split_after,
    output logic [PCOUNT_W-1:0] o_piece_count,
    output logic                o_overflow,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int unsigned DEPTH = MAX_PIECES - 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_PIECES + 1);
    localparam int unsigned PW    = FRAC_W + HEIGHT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC,
        S_CAND,
        S_CLAT,
        S_COUNT,
        S_RATIO
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_cnt, n_cnt;
    logic [COORD_W-1:0]  r_prev, n_prev;
    logic                r_ovf, n_ovf;
    logic [COORD_W-1:0]  r_wide, n_wide;
    logic [AW-1:0]       r_at, n_at;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_less, n_less;
    logic [CW-1:0]       r_le, n_le;
    logic [COORD_W-1:0]  r_cand, n_cand;

    logic                r_done, n_done;
    logic                r_found, n_found;
    logic [AFTER_W-1:0]  r_after, n_after;
    logic [PCOUNT_W-1:0] r_pcount, n_pcount;
    logic                r_ovf_out, n_ovf_out;

    logic [HEIGHT_W-1:0] r_mh;
    logic [FRAC_W-1:0]   r_gf;
    logic [FRAC_W-1:0]   r_gr;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COORD_W-1:0]  gap;
    logic [AW-1:0]       rd_addr;
    logic [COORD_W-1:0]  rd_data;

    logic                accept;
    logic [CW-1:0]       gaps;
    logic [CW-1:0]       k_pos;
    logic [PW-1:0]       wide16;
    logic [PW-1:0]       prod_frac;
    logic [PW-1:0]       prod_ratio;
    logic                eligible;
    logic                pass_frac;
    logic [CW-1:0]       less_f;
    logic [CW-1:0]       le_f;
    logic                finish;
    logic                fin_found;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mh <= MEDIAN_HEIGHT_RST;
            r_gf <= GAP_FRACTION_RST;
            r_gr <= GAP_RATIO_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MEDIAN_HEIGHT: r_mh <= pwdata[HEIGHT_W-1:0];
                REG_GAP_FRACTION:  r_gf <= pwdata[FRAC_W-1:0];
                REG_GAP_RATIO:     r_gr <= pwdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MEDIAN_HEIGHT: prdata = APB_DW'(r_mh);
            REG_GAP_FRACTION:  prdata = APB_DW'(r_gf);
            REG_GAP_RATIO:     prdata = APB_DW'(r_gr);
            default:           prdata = '0;
        endcase
    end

    // ---------------- gap store ----------------
    wgrs_gap_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_gap_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (gap),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------- datapath helpers ----------------
    assign accept     = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign gap        = (i_left_x > r_prev) ? (i_left_x - r_prev) : '0;
    assign wr_en      = accept && (r_cnt < CW'(MAX_PIECES)) && (r_cnt != '0);
    assign wr_addr    = AW'(r_cnt - CW'(1));
    assign gaps       = r_cnt - CW'(1);
    assign k_pos      = (gaps - CW'(1)) >> 1;
    assign wide16     = PW'({r_wide, 4'b0000});
    assign prod_frac  = PW'(r_gf) * PW'(r_mh);
    assign prod_ratio = PW'(r_gr) * PW'(r_cand);
    assign eligible   = (r_cnt >= CW'(2)) && !r_ovf && (r_mh != '0);
    assign pass_frac  = eligible && (wide16 > prod_frac);
    assign less_f     = r_less + CW'(rd_data < r_cand);
    assign le_f       = r_le + CW'(rd_data <= r_cand);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_ovf     = r_ovf;
        n_wide    = r_wide;
        n_at      = r_at;
        n_j       = r_j;
        n_i       = r_i;
        n_less    = r_less;
        n_le      = r_le;
        n_cand    = r_cand;
        rd_addr   = '0;
        finish    = 1'b0;
        fin_found = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_cnt >= CW'(MAX_PIECES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        // first widest: only a strictly larger gap moves it
                        if (r_cnt == CW'(1) || (r_cnt != '0 && gap > r_wide)) begin
                            n_wide = gap;
                            n_at   = wr_addr;
                        end
                        n_cnt = r_cnt + CW'(1);
                    end
                    n_prev = i_last_piece ? '0 : i_right_x;
                    if (i_last_piece) begin
                        n_state = S_FRAC;
                    end
                end
            end
            S_FRAC: begin
                if (pass_frac && gaps >= CW'(2)) begin
                    n_j     = '0;
                    n_state = S_CAND;
                end else begin
                    finish    = 1'b1;
                    fin_found = pass_frac;
                end
            end
            S_CAND: begin
                rd_addr = AW'(r_j);
                n_state = S_CLAT;
            end
            S_CLAT: begin
                n_cand  = rd_data;
                rd_addr = '0;
                n_i     = '0;
                n_less  = '0;
                n_le    = '0;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                n_less = less_f;
                n_le   = le_f;
                if (r_i == gaps - CW'(1)) begin
                    // candidate holds sorted position k of all gaps: the
                    // widest removed only drops the top, so this is the median
                    if (less_f <= k_pos && le_f > k_pos) begin
                        n_state = S_RATIO;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_CAND;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    rd_addr = AW'(r_i + CW'(1));
                end
            end
            S_RATIO: begin
                finish    = 1'b1;
                fin_found = wide16 > prod_ratio;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_done    = finish;
        n_found   = r_found;
        n_after   = r_after;
        n_pcount  = r_pcount;
        n_ovf_out = r_ovf_out;
        if (finish) begin
            n_found   = fin_found;
            n_after   = fin_found ? AFTER_W'(r_at) : '0;
            n_pcount  = PCOUNT_W'(r_cnt);
            n_ovf_out = r_ovf;
            n_cnt     = '0;
            n_ovf     = 1'b0;
            n_state   = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_prev    <= '0;
            r_ovf     <= 1'b0;
            r_done    <= 1'b0;
            r_wide    <= '0;
            r_at      <= '0;
            r_j       <= '0;
            r_i       <= '0;
            r_less    <= '0;
            r_le      <= '0;
            r_cand    <= '0;
            r_found   <= 1'b0;
            r_after   <= '0;
            r_pcount  <= '0;
            r_ovf_out <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_prev    <= n_prev;
            r_ovf     <= n_ovf;
            r_done    <= n_done;
            r_wide    <= n_wide;
            r_at      <= n_at;
            r_j       <= n_j;
            r_i       <= n_i;
            r_less    <= n_less;
            r_le      <= n_le;
            r_cand    <= n_cand;
            r_found   <= n_found;
            r_after   <= n_after;
            r_pcount  <= n_pcount;
            r_ovf_out <= n_ovf_out;
        end
    end

    assign o_done        = r_done;
    assign o_split_found = r_found;
    assign o_split_after = r_after;
    assign o_piece_count = r_pcount;
    assign o_overflow    = r_ovf_out;

    // ---------------- assertions ----------------
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_split_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_split_found) |-> !o_overflow)
        else $error("split reported on overflowed row");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_piece) |=> busy)
        else $error("last piece did not start end-of-row work");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_PIECES))
        else $error("piece counter beyond store size");

endmodule
